[design/pfs_pkg.sv]
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared constants for the placement file sniffer: flag bit positions,
// pattern bytes and the per-letter refdes watch codes.
// ----------------------------------------------------------------------------
package pfs_pkg;

  typedef logic [7:0] byte_t;

  // Sticky evidence flags, one bit each.
  localparam int FLAG_W     = 11;
  localparam int F_BINARY   = 0;
  localparam int F_G54      = 1;
  localparam int F_M00      = 2;
  localparam int F_M02      = 3;
  localparam int F_G02      = 4;
  localparam int F_ADD      = 5;
  localparam int F_COMMA    = 6;
  localparam int F_R        = 7;
  localparam int F_C        = 8;
  localparam int F_U        = 9;
  localparam int F_SIDE     = 10;

  typedef logic [FLAG_W-1:0] flags_t;

  // Refdes watch codes for each of R, C and U.
  typedef logic [1:0] watch_t;
  localparam watch_t WATCH_NONE    = 2'd0;
  localparam watch_t WATCH_PREV    = 2'd1;
  localparam watch_t WATCH_DECIDED = 2'd2;

  localparam int NUM_LETTERS = 3;
  localparam byte_t WATCH_LETTER [NUM_LETTERS] = '{8'h52, 8'h43, 8'h55}; // R C U
  localparam int    WATCH_FLAG   [NUM_LETTERS] = '{F_R, F_C, F_U};

  // Control bytes.
  localparam byte_t CH_NUL = 8'h00;
  localparam byte_t CH_TAB = 8'h09;
  localparam byte_t CH_LF  = 8'h0A;
  localparam byte_t CH_CR  = 8'h0D;

  // Three-byte patterns, oldest byte in the high bits.
  localparam logic [23:0] PAT_G54 = 24'h473534;
  localparam logic [23:0] PAT_M00 = 24'h4D3030;
  localparam logic [23:0] PAT_M02 = 24'h4D3032;
  localparam logic [23:0] PAT_G02 = 24'h473032;
  localparam logic [23:0] PAT_ADD = 24'h414444;
  localparam logic [23:0] PAT_TOP_L = 24'h746F70; // top
  localparam logic [23:0] PAT_TOP_M = 24'h546F70; // Top
  localparam logic [23:0] PAT_TOP_U = 24'h544F50; // TOP

  // Four-byte patterns.
  localparam logic [31:0] PAT_AYER_L = 32'h61796572; // ayer
  localparam logic [31:0] PAT_AYER_U = 32'h41594552; // AYER

endpackage

[design/placement_file_sniffer.sv]
// ----------------------------------------------------------------------------
// placement_file_sniffer
// Scans a file one byte per word and judges whether it is a component
// placement listing; an end-of-file word returns the verdict and clears state.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Content
//  --------+-----------+----------------------------------------------------
//  in_     | slave     | tdata: data_byte[7:0]; tuser: cmd (1 = end of file)
//  out_    | master    | tdata: is_placement_file[0], binary_seen[1]
//
// One word per clock is sustained while no end-of-file word waits on a full
// output. Each word is held in the input register, and the scan logic updates
// the chunk state as the word leaves it. Only an end-of-file word produces a
// result, offered from the result register once the word has passed the input
// register. A stalled result holds in the output register; data words keep
// flowing past it, and only an end-of-file word waits for the output to free up.
// Reset (rst_n low, synchronous) clears all chunk state and flags.
// ----------------------------------------------------------------------------
module placement_file_sniffer #(
  parameter int LINE_BUF = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] cmd
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] is_placement_file, [1] binary_seen, rest zero
);

  localparam int CW = $clog2(LINE_BUF);

  // Input register.
  logic                s1_valid_r;
  logic                s1_cmd_r;
  pfs_pkg::byte_t      s1_byte_r;

  // Chunk and evidence state.
  logic [23:0]         recent_r,  recent_nxt;
  logic [CW-1:0]       cnt_r,     cnt_nxt;
  logic                muted_r,   muted_nxt;
  pfs_pkg::watch_t     watch_r   [pfs_pkg::NUM_LETTERS];
  pfs_pkg::watch_t     watch_nxt [pfs_pkg::NUM_LETTERS];
  pfs_pkg::flags_t     flags_r,   flags_nxt;

  // Result register.
  logic                out_valid_r;
  logic [1:0]          out_data_r;

  logic                out_free;
  logic                s1_fire;
  logic                visible;
  logic [23:0]         w3;
  logic [31:0]         w4;
  logic [CW-1:0]       cnt_inc;
  logic                chunk_end;
  logic                verdict;

  // Handshake: the scan stage moves on unless an end word meets a full output.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_cmd_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_byte_r <= in_tdata;
    end
  end

  // Byte scan: windows, marker matches, refdes watch and chunk bookkeeping.
  assign w3      = {recent_r[15:0], s1_byte_r};
  assign w4      = {recent_r, s1_byte_r};
  assign cnt_inc = cnt_r + CW'(1);

  assign verdict = (flags_r[pfs_pkg::F_ADD:pfs_pkg::F_G54] == '0) &&
                   flags_r[pfs_pkg::F_COMMA] &&
                   (flags_r[pfs_pkg::F_U:pfs_pkg::F_R] != '0) &&
                   flags_r[pfs_pkg::F_SIDE];

  always_comb begin
    recent_nxt = recent_r;
    cnt_nxt    = cnt_r;
    muted_nxt  = muted_r;
    flags_nxt  = flags_r;
    for (int k = 0; k < pfs_pkg::NUM_LETTERS; k++) begin
      watch_nxt[k] = watch_r[k];
    end

    visible   = !(muted_r || (s1_byte_r == pfs_pkg::CH_NUL));
    chunk_end = (s1_byte_r == pfs_pkg::CH_LF) || (cnt_inc == CW'(LINE_BUF - 1));

    if (s1_fire) begin
      if (s1_cmd_r) begin
        // End of file clears everything.
        recent_nxt = '0;
        cnt_nxt    = '0;
        muted_nxt  = 1'b0;
        flags_nxt  = '0;
        for (int k = 0; k < pfs_pkg::NUM_LETTERS; k++) begin
          watch_nxt[k] = pfs_pkg::WATCH_NONE;
        end
      end else begin
        muted_nxt = !visible;
        if (visible) begin
          if ((s1_byte_r < 8'h20 || s1_byte_r > 8'h7E) &&
              s1_byte_r != pfs_pkg::CH_CR && s1_byte_r != pfs_pkg::CH_LF &&
              s1_byte_r != pfs_pkg::CH_TAB) begin
            flags_nxt[pfs_pkg::F_BINARY] = 1'b1;
          end
          if (w3 == pfs_pkg::PAT_G54) flags_nxt[pfs_pkg::F_G54] = 1'b1;
          if (w3 == pfs_pkg::PAT_M00) flags_nxt[pfs_pkg::F_M00] = 1'b1;
          if (w3 == pfs_pkg::PAT_M02) flags_nxt[pfs_pkg::F_M02] = 1'b1;
          if (w3 == pfs_pkg::PAT_G02) flags_nxt[pfs_pkg::F_G02] = 1'b1;
          if (w3 == pfs_pkg::PAT_ADD) flags_nxt[pfs_pkg::F_ADD] = 1'b1;
          if (s1_byte_r == 8'h2C || s1_byte_r == 8'h3B) begin
            flags_nxt[pfs_pkg::F_COMMA] = 1'b1;
          end
          if (w3 == pfs_pkg::PAT_TOP_L || w3 == pfs_pkg::PAT_TOP_M ||
              w3 == pfs_pkg::PAT_TOP_U || w4 == pfs_pkg::PAT_AYER_L ||
              w4 == pfs_pkg::PAT_AYER_U) begin
            flags_nxt[pfs_pkg::F_SIDE] = 1'b1;
          end

          // The first R, C or U of a chunk counts when a digit follows it.
          for (int k = 0; k < pfs_pkg::NUM_LETTERS; k++) begin
            if (watch_r[k] == pfs_pkg::WATCH_PREV) begin
              if (s1_byte_r >= 8'h30 && s1_byte_r <= 8'h39) begin
                flags_nxt[pfs_pkg::WATCH_FLAG[k]] = 1'b1;
              end
              watch_nxt[k] = pfs_pkg::WATCH_DECIDED;
            end else if (watch_r[k] == pfs_pkg::WATCH_NONE &&
                         s1_byte_r == pfs_pkg::WATCH_LETTER[k]) begin
              watch_nxt[k] = pfs_pkg::WATCH_PREV;
            end
          end

          recent_nxt = w3;
        end

        // Hidden bytes still count, and a hidden newline still ends the chunk.
        cnt_nxt = cnt_inc;
        if (chunk_end) begin
          recent_nxt = '0;
          cnt_nxt    = '0;
          muted_nxt  = 1'b0;
          for (int k = 0; k < pfs_pkg::NUM_LETTERS; k++) begin
            watch_nxt[k] = pfs_pkg::WATCH_NONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      cnt_r    <= '0;
      muted_r  <= 1'b0;
      flags_r  <= '0;
      for (int k = 0; k < pfs_pkg::NUM_LETTERS; k++) begin
        watch_r[k] <= pfs_pkg::WATCH_NONE;
      end
    end else begin
      recent_r <= recent_nxt;
      cnt_r    <= cnt_nxt;
      muted_r  <= muted_nxt;
      flags_r  <= flags_nxt;
      for (int k = 0; k < pfs_pkg::NUM_LETTERS; k++) begin
        watch_r[k] <= watch_nxt[k];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_cmd_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_cmd_r) begin
      out_data_r <= {flags_r[pfs_pkg::F_BINARY], verdict};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};

  // Checks.
  a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_cmd_r) |=> (flags_r == '0 && cnt_r == '0 && recent_r == '0))
    else $error("state not cleared after end of file");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r < CW'(LINE_BUF - 1)))
    else $error("chunk count reached the chunk limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !(s1_fire && s1_cmd_r))
    else $error("pending result overwritten");

  a_watch_code: assert property (@(posedge clk) disable iff (!rst_n)
    (watch_r[0] <= pfs_pkg::WATCH_DECIDED && watch_r[1] <= pfs_pkg::WATCH_DECIDED &&
     watch_r[2] <= pfs_pkg::WATCH_DECIDED))
    else $error("refdes watch holds an unused code");

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for placement_file_sniffer. Files are streamed in as
// byte words followed by an end-of-file word; a scan model in the bench
// tracks chunks, refdes letters and sticky marker flags and queues the
// verdict that each end-of-file word must return. Both stream sides idle
// at random, and one phase holds the result side off long enough to stall
// the input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // A short line buffer makes length-limited chunk ends frequent.
  localparam int CHUNK_BUF    = 32;
  localparam int RANDOM_WORDS = 1350;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;

  localparam pfs_pkg::byte_t CH_SPACE = 8'h20;
  localparam pfs_pkg::byte_t CH_TILDE = 8'h7E;
  localparam pfs_pkg::byte_t CH_COMMA = 8'h2C;
  localparam pfs_pkg::byte_t CH_SEMI  = 8'h3B;
  localparam pfs_pkg::byte_t CH_ZERO  = 8'h30;
  localparam pfs_pkg::byte_t CH_NINE  = 8'h39;

  typedef struct packed {
    logic is_placement_file;
    logic binary_seen;
  } verdict_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic       in_tuser;   // [0] cmd
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [0] is_placement_file, [1] binary_seen

  // Scan model state.
  logic [23:0]     scan_recent;
  int unsigned     scan_len;
  logic            scan_muted;
  pfs_pkg::watch_t scan_watch [pfs_pkg::NUM_LETTERS];
  pfs_pkg::flags_t scan_flags;

  verdict_t verdict_q [$];
  int       mismatch_count = 0;
  int       results_seen = 0;
  int       words_sent = 0;
  bit       in_idle_on = 1'b0;
  bit       out_idle_on = 1'b0;
  int       hold_req = 0;
  int       hold_ack = 0;

  string field_tok [22] = '{"R1", "C22", "U305", "R", "C", "U", "10k", "0603", ",",
                            ",", ";", "top", "Top", "TOP", "Layer", "LAYER",
                            "bottom", " ", " ", "\t", "x", "12.5"};
  string gerber_tok [5] = '{"G54", "M00", "M02", "G02", "ADD"};

  placement_file_sniffer #(.LINE_BUF(CHUNK_BUF)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Clear the per-chunk part of the scan model.
  function automatic void open_chunk();
    scan_recent = '0;
    scan_len = 0;
    scan_muted = 1'b0;
    for (int k = 0; k < pfs_pkg::NUM_LETTERS; k++) scan_watch[k] = pfs_pkg::WATCH_NONE;
  endfunction

  // Advance the scan model by one accepted word; an end-of-file word
  // queues the verdict and clears everything.
  function automatic void scan_word(input logic eof, input pfs_pkg::byte_t b);
    logic [31:0] win4;
    logic [23:0] win3;
    verdict_t    v;
    if (eof) begin
      v.is_placement_file = !(scan_flags[pfs_pkg::F_G54] | scan_flags[pfs_pkg::F_M00] |
                              scan_flags[pfs_pkg::F_M02] | scan_flags[pfs_pkg::F_G02] |
                              scan_flags[pfs_pkg::F_ADD]) &&
                            scan_flags[pfs_pkg::F_COMMA] &&
                            (scan_flags[pfs_pkg::F_R] | scan_flags[pfs_pkg::F_C] |
                             scan_flags[pfs_pkg::F_U]) &&
                            scan_flags[pfs_pkg::F_SIDE];
      v.binary_seen = scan_flags[pfs_pkg::F_BINARY];
      verdict_q.push_back(v);
      open_chunk();
      scan_flags = '0;
    end else begin
      // A zero byte hides itself and the rest of its chunk.
      if (b == pfs_pkg::CH_NUL) scan_muted = 1'b1;
      if (!scan_muted) begin
        win4 = {scan_recent, b};
        win3 = win4[23:0];
        if ((b < CH_SPACE || b > CH_TILDE) && b != pfs_pkg::CH_CR &&
            b != pfs_pkg::CH_LF && b != pfs_pkg::CH_TAB)
          scan_flags[pfs_pkg::F_BINARY] = 1'b1;
        if (win3 == pfs_pkg::PAT_G54) scan_flags[pfs_pkg::F_G54] = 1'b1;
        if (win3 == pfs_pkg::PAT_M00) scan_flags[pfs_pkg::F_M00] = 1'b1;
        if (win3 == pfs_pkg::PAT_M02) scan_flags[pfs_pkg::F_M02] = 1'b1;
        if (win3 == pfs_pkg::PAT_G02) scan_flags[pfs_pkg::F_G02] = 1'b1;
        if (win3 == pfs_pkg::PAT_ADD) scan_flags[pfs_pkg::F_ADD] = 1'b1;
        if (b == CH_COMMA || b == CH_SEMI) scan_flags[pfs_pkg::F_COMMA] = 1'b1;
        if (win3 == pfs_pkg::PAT_TOP_L || win3 == pfs_pkg::PAT_TOP_M ||
            win3 == pfs_pkg::PAT_TOP_U || win4 == pfs_pkg::PAT_AYER_L ||
            win4 == pfs_pkg::PAT_AYER_U)
          scan_flags[pfs_pkg::F_SIDE] = 1'b1;
        // Only the first R, C or U of a chunk is judged, by the next visible byte.
        for (int k = 0; k < pfs_pkg::NUM_LETTERS; k++) begin
          if (scan_watch[k] == pfs_pkg::WATCH_PREV) begin
            if (b >= CH_ZERO && b <= CH_NINE) scan_flags[pfs_pkg::WATCH_FLAG[k]] = 1'b1;
            scan_watch[k] = pfs_pkg::WATCH_DECIDED;
          end else if (scan_watch[k] == pfs_pkg::WATCH_NONE &&
                       b == pfs_pkg::WATCH_LETTER[k]) begin
            scan_watch[k] = pfs_pkg::WATCH_PREV;
          end
        end
        scan_recent = win3;
      end
      // Hidden bytes still count, and a hidden newline still ends the chunk.
      scan_len++;
      if (b == pfs_pkg::CH_LF || scan_len >= CHUNK_BUF - 1) open_chunk();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offer one word, after a random gap when input idling is on, and wait until it is taken.
  task automatic send_word(input logic eof, input pfs_pkg::byte_t b);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= eof;
    do @(posedge clk); while (!in_tready);
    scan_word(eof, b);
    words_sent++;
  endtask

  // Send a text as byte words, then an end-of-file word with a random byte.
  task automatic send_file(input string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, pfs_pkg::byte_t'(s[i]));
    send_word(1'b1, pfs_pkg::byte_t'($urandom_range(0, 255)));
  endtask

  // Result side: random stalls per word, plus a long hold-off on request.
  initial begin : result_sink
    int       stall_left;
    int       hold_left;
    verdict_t want;
    stall_left = 0;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result %0d: word %h with nothing expected",
                                    results_seen, out_tdata));
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[0] !== want.is_placement_file)
            report_mismatch($sformatf("result %0d: is_placement_file got %b expected %b",
                                      results_seen, out_tdata[0], want.is_placement_file));
          if (out_tdata[1] !== want.binary_seen)
            report_mismatch($sformatf("result %0d: binary_seen got %b expected %b",
                                      results_seen, out_tdata[1], want.binary_seen));
        end
        stall_left = out_idle_on ? $urandom_range(0, 15) : 0;
      end
      if (hold_ack != hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_ack = hold_req;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Hand-picked files: empty file, a clean listing, a refdes letter that
  // ends its chunk, a binary byte with a zero byte hiding a digit, and a Gerber marker.
  task automatic test_directed();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    send_word(1'b1, 8'hFF);
    send_file("C7;Top");
    send_file("U\n9,top");
    send_word(1'b0, 8'hFF);
    send_word(1'b0, pfs_pkg::WATCH_LETTER[0]);
    send_word(1'b0, pfs_pkg::CH_NUL);
    send_word(1'b0, CH_ZERO + 8'd5);
    send_word(1'b1, 8'h00);
    send_file("ADD");
  endtask

  // Hold the result side off while short files keep coming, so that
  // finished verdicts pile up and the input stalls.
  task automatic test_backpressure();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    hold_req++;
    for (int n = 0; n < 6; n++) send_file("R5,top\n");
    out_idle_on = 1'b1;
  endtask

  // Random files: mostly lines of listing-like fields, some with cut-off
  // fields, some plain noise. Idling is switched per file.
  task automatic test_random_files();
    pfs_pkg::byte_t file_q [$];
    int    kind;
    int    lines;
    int    toks;
    int    cut;
    string tok;
    while (words_sent < RANDOM_WORDS) begin
      file_q.delete();
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 40))
          file_q.push_back(pfs_pkg::byte_t'($urandom_range(0, 255)));
      end else begin
        lines = $urandom_range(1, 4);
        repeat (lines) begin
          toks = $urandom_range(1, 6);
          repeat (toks) begin
            if ($urandom_range(0, 39) == 0) begin
              file_q.push_back(pfs_pkg::byte_t'($urandom_range(0, 255)));
            end else begin
              if ($urandom_range(0, 29) == 0) tok = gerber_tok[$urandom_range(0, 4)];
              else tok = field_tok[$urandom_range(0, 21)];
              cut = (kind == 1) ? $urandom_range(1, tok.len()) : tok.len();
              for (int i = 0; i < cut; i++) file_q.push_back(pfs_pkg::byte_t'(tok[i]));
            end
          end
          if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 3) == 0) file_q.push_back(pfs_pkg::CH_CR);
            file_q.push_back(pfs_pkg::CH_LF);
          end
        end
      end
      foreach (file_q[i]) send_word(1'b0, file_q[i]);
      send_word(1'b1, pfs_pkg::byte_t'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    open_chunk();
    scan_flags = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_files();
    in_tvalid <= 1'b0;

    // Let every verdict come out, then watch a little longer for strays.
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** placement_file_sniffer: PASSED **");
    end else begin
      $display("** placement_file_sniffer: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d verdicts outstanding", verdict_q.size());
    $display("** placement_file_sniffer: FAILED **");
    $finish;
  end

endmodule

[placement_file_sniffer.f]
design/pfs_pkg.sv
design/placement_file_sniffer.sv
sim/testbench.sv
